// ----- src/reliable_channel_sequencer_core_macros.svh -----
// Assertion macros used by the sequencer checker.
// Each macro expects signals named clk and arst_n in the enclosing scope.
`ifndef RELIABLE_CHANNEL_SEQUENCER_CORE_MACROS_SVH
`define RELIABLE_CHANNEL_SEQUENCER_CORE_MACROS_SVH

// same-cycle implication
`define RCS_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define RCS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ----- src/rcs_pkg.sv -----
// Package for the reliable channel sequencer: widths, codes, item and result types.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none
package rcs_pkg;

	localparam int unsigned SEQ_W            = 31;
	localparam int unsigned LEN_W            = 12;
	localparam int unsigned SIZE_W           = 13;
	localparam int unsigned SUM_W            = 14;
	localparam int unsigned TAG_W            = 16;
	localparam int unsigned MAX_PACKET_BYTES = 2048;
	localparam int unsigned HDR_BYTES        = 8;
	localparam int unsigned TAG_BYTES        = 2;

	localparam int unsigned APB_ADDR_W = 3;
	localparam int unsigned APB_DATA_W = 32;
	localparam int unsigned IN_DATA_W  = 96;
	localparam int unsigned OUT_DATA_W = 128;

	localparam logic REG_IS_CLIENT = 1'b0;
	localparam logic REG_PORT_TAG  = 1'b1;

	typedef enum logic {
		OP_TRANSMIT = 1'b0,
		OP_RECEIVE  = 1'b1
	} opcode_t;

	typedef enum logic [1:0] {
		ST_BUILT    = 2'd0,
		ST_ACCEPTED = 2'd1,
		ST_STALE    = 2'd2,
		ST_FATAL    = 2'd3
	} status_t;

	typedef struct packed {
		logic             is_client;
		logic [TAG_W-1:0] port_tag;
	} cfg_t;

	typedef struct packed {
		opcode_t          opcode;
		logic [SEQ_W-1:0] rx_sequence;
		logic             rx_reliable_flag;
		logic [SEQ_W-1:0] rx_ack_sequence;
		logic             rx_reliable_ack;
		logic [LEN_W-1:0] pending_length;
		logic             pending_overflow;
		logic [LEN_W-1:0] unreliable_length;
	} item_t;

	typedef struct packed {
		status_t          status;
		logic [31:0]      header_first;
		logic [31:0]      header_second;
		logic             with_port_tag;
		logic             reliable_included;
		logic [LEN_W-1:0] reliable_bytes;
		logic             unreliable_included;
		logic [LEN_W-1:0] packet_bytes;
		logic             pending_taken;
		logic [SEQ_W-1:0] dropped_count;
	} result_t;

endpackage
`default_nettype wire

// ----- src/reliable_channel_sequencer_core.sv -----
// Reliable channel sequencer: input register, sequencing engine, result register.
// Depends on rcs_pkg, rcs_apb_regs and rcs_seq_engine.
//
// Input stream s_axis carries one transaction per packet event: tuser selects
// transmit or receive, tdata carries the header fields and buffer lengths.
// Output stream m_axis returns exactly one result transaction per input:
// tuser is the status code, tdata the header words, sizes and counters.
// The APB port sets is_client (address 0) and port_tag (address 4); write
// it only while no transaction is in flight.
// m_axis_tvalid rises once a transaction has gone from the input register
// through the engine into the result register. One transaction is accepted
// every cycle while m_axis_tready stays high; the limit is the single engine
// pass between the input register and the result register, which also
// updates the sequence state.
// Reset clears both pipeline valids and returns the sequence state to
// out_sequence 1 with everything else zero. When m_axis_tready is low the
// result holds, the input register keeps the next transaction, and
// s_axis_tready stays low while the input register is full.
`timescale 1ns / 1ps
`default_nettype none
module reliable_channel_sequencer_core
	import rcs_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_axis_tvalid,
	output logic                       s_axis_tready,
	// [30:0] rx_sequence, [31] rx_reliable_flag, [62:32] rx_ack_sequence,
	// [63] rx_reliable_ack, [75:64] pending_length, [76] pending_overflow,
	// [88:77] unreliable_length, [95:89] zero
	input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
	// [0] opcode
	input  wire logic                  s_axis_tuser,
	output logic                       m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	// [31:0] header_first, [63:32] header_second, [64] with_port_tag,
	// [65] reliable_included, [77:66] reliable_bytes, [78] unreliable_included,
	// [90:79] packet_bytes, [91] pending_taken, [122:92] dropped_count,
	// [127:123] zero
	output logic      [OUT_DATA_W-1:0] m_axis_tdata,
	// [1:0] status
	output logic      [1:0]            m_axis_tuser,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [APB_ADDR_W-1:0] paddr,
	input  wire logic [APB_DATA_W-1:0] pwdata,
	output logic      [APB_DATA_W-1:0] prdata,
	output logic                       pready
);

	cfg_t    cfg;
	item_t   item_in;
	item_t   item_s1;
	logic    valid_s1;
	logic    advance;
	result_t result;
	result_t res_s2;
	logic    valid_s2;

	rcs_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign item_in.opcode            = opcode_t'(s_axis_tuser);
	assign item_in.rx_sequence       = s_axis_tdata[30:0];
	assign item_in.rx_reliable_flag  = s_axis_tdata[31];
	assign item_in.rx_ack_sequence   = s_axis_tdata[62:32];
	assign item_in.rx_reliable_ack   = s_axis_tdata[63];
	assign item_in.pending_length    = s_axis_tdata[75:64];
	assign item_in.pending_overflow  = s_axis_tdata[76];
	assign item_in.unreliable_length = s_axis_tdata[88:77];

	assign advance       = valid_s1 & (~valid_s2 | m_axis_tready);
	assign s_axis_tready = ~valid_s1 | advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tvalid && s_axis_tready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			item_s1 <= item_in;
		end
	end

	rcs_seq_engine u_engine (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.item    (item_s1),
		.cfg     (cfg),
		.result  (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_axis_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= result;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tuser  = res_s2.status;
	assign m_axis_tdata  = {
		5'b0,
		res_s2.dropped_count,
		res_s2.pending_taken,
		res_s2.packet_bytes,
		res_s2.unreliable_included,
		res_s2.reliable_bytes,
		res_s2.reliable_included,
		res_s2.with_port_tag,
		res_s2.header_second,
		res_s2.header_first
	};

endmodule
`default_nettype wire

// ----- src/rcs_apb_regs.sv -----
// APB configuration registers of the sequencer: is_client and port_tag.
// Depends on rcs_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rcs_apb_regs
	import rcs_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [APB_ADDR_W-1:0] paddr,
	input  wire logic [APB_DATA_W-1:0] pwdata,
	output logic      [APB_DATA_W-1:0] prdata,
	output logic                       pready,
	output cfg_t                       cfg
);

	logic             is_client_q;
	logic [TAG_W-1:0] port_tag_q;
	logic             wr_en;
	logic             reg_sel;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite & pready;
	assign reg_sel = paddr[APB_ADDR_W-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			is_client_q <= 1'b1;
			port_tag_q  <= '0;
		end else if (wr_en) begin
			case (reg_sel)
				REG_IS_CLIENT: is_client_q <= pwdata[0];
				REG_PORT_TAG:  port_tag_q  <= pwdata[TAG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_IS_CLIENT: prdata = {{(APB_DATA_W-1){1'b0}}, is_client_q};
			REG_PORT_TAG:  prdata = {{(APB_DATA_W-TAG_W){1'b0}}, port_tag_q};
			default:       prdata = '0;
		endcase
	end

	assign cfg.is_client = is_client_q;
	assign cfg.port_tag  = port_tag_q;

endmodule
`default_nettype wire

// ----- src/rcs_seq_engine.sv -----
// Sequencing state and single-pass transmit/receive logic of the channel.
// Depends on rcs_pkg; state advances when the top level moves an item to its result register.
`timescale 1ns / 1ps
`default_nettype none
module rcs_seq_engine
	import rcs_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    advance,
	input  item_t        item,
	input  cfg_t         cfg,
	output result_t      result
);

	logic [SEQ_W-1:0] out_seq_q;
	logic [SEQ_W-1:0] in_seq_q;
	logic [SEQ_W-1:0] in_ack_q;
	logic             in_rel_ack_q;
	logic             in_rel_tog_q;
	logic             rel_tog_q;
	logic [SEQ_W-1:0] last_rel_q;
	logic [LEN_W-1:0] held_len_q;
	logic             fatal_q;

	logic             is_tx;
	logic             overflow;
	logic             send_ack;
	logic             latch;
	logic             send_rel;
	logic [LEN_W-1:0] held_tx;
	logic [SEQ_W-1:0] out_seq_inc;
	logic [SIZE_W-1:0] size;
	logic [SUM_W-1:0] sum;
	logic             fits;
	logic [SUM_W-1:0] total;
	logic [LEN_W-1:0] packet;
	logic             stale;
	logic [SEQ_W-1:0] dropped;
	logic             rel_cleared;
	logic [LEN_W-1:0] held_rx;

	assign is_tx    = (item.opcode == OP_TRANSMIT);
	assign overflow = item.pending_overflow;

	// transmit path
	assign send_ack    = (in_ack_q > last_rel_q) && (in_rel_ack_q != rel_tog_q);
	assign latch       = (held_len_q == '0) && (item.pending_length != '0);
	assign send_rel    = send_ack | latch;
	assign held_tx     = latch ? item.pending_length : held_len_q;
	assign out_seq_inc = out_seq_q + SEQ_W'(1);

	assign size = SIZE_W'(HDR_BYTES)
		+ (cfg.is_client ? SIZE_W'(TAG_BYTES) : SIZE_W'(0))
		+ (send_rel ? {1'b0, held_tx} : SIZE_W'(0));
	assign sum    = {1'b0, size} + SUM_W'(item.unreliable_length);
	assign fits   = (sum <= SUM_W'(MAX_PACKET_BYTES));
	assign total  = fits ? sum : {1'b0, size};
	assign packet = (total > SUM_W'({LEN_W{1'b1}})) ? {LEN_W{1'b1}} : total[LEN_W-1:0];

	// receive path
	assign stale       = (item.rx_sequence <= in_seq_q);
	assign dropped     = item.rx_sequence - in_seq_q - SEQ_W'(1);
	assign rel_cleared = (item.rx_reliable_ack == rel_tog_q);
	assign held_rx     = rel_cleared ? '0 : held_len_q;

	always_comb begin
		result = '0;
		if (is_tx) begin
			if (overflow) begin
				result.status = ST_FATAL;
			end else begin
				result.status              = ST_BUILT;
				result.header_first        = {send_rel, out_seq_q};
				result.header_second       = {in_rel_tog_q, in_seq_q};
				result.with_port_tag       = cfg.is_client;
				result.reliable_included   = send_rel;
				result.reliable_bytes      = held_tx;
				result.unreliable_included = fits;
				result.packet_bytes        = packet;
				result.pending_taken       = latch;
			end
		end else begin
			if (stale) begin
				result.status         = ST_STALE;
				result.reliable_bytes = held_len_q;
			end else begin
				result.status         = ST_ACCEPTED;
				result.reliable_bytes = held_rx;
				result.dropped_count  = dropped;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_seq_q    <= SEQ_W'(1);
			in_seq_q     <= '0;
			in_ack_q     <= '0;
			in_rel_ack_q <= 1'b0;
			in_rel_tog_q <= 1'b0;
			rel_tog_q    <= 1'b0;
			last_rel_q   <= '0;
			held_len_q   <= '0;
			fatal_q      <= 1'b0;
		end else if (advance) begin
			if (is_tx) begin
				if (overflow) begin
					fatal_q <= 1'b1;
				end else begin
					out_seq_q  <= out_seq_inc;
					held_len_q <= held_tx;
					if (latch) begin
						rel_tog_q <= ~rel_tog_q;
					end
					if (send_rel) begin
						last_rel_q <= out_seq_inc;
					end
				end
			end else if (!stale) begin
				in_seq_q     <= item.rx_sequence;
				in_ack_q     <= item.rx_ack_sequence;
				in_rel_ack_q <= item.rx_reliable_ack;
				held_len_q   <= held_rx;
				if (item.rx_reliable_flag) begin
					in_rel_tog_q <= ~in_rel_tog_q;
				end
			end
		end
	end

endmodule
`default_nettype wire

// ----- src/rcs_checker.sv -----
// Port-level checker for reliable_channel_sequencer_core, bound to the top level.
// Depends on rcs_pkg and reliable_channel_sequencer_core_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "reliable_channel_sequencer_core_macros.svh"
module rcs_checker
	import rcs_pkg::*;
(
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  m_axis_tvalid,
	input wire logic                  m_axis_tready,
	input wire logic [OUT_DATA_W-1:0] m_axis_tdata,
	input wire logic [1:0]            m_axis_tuser
);

	logic built;
	logic fatal;

	assign built = m_axis_tvalid && (m_axis_tuser == ST_BUILT);
	assign fatal = m_axis_tvalid && (m_axis_tuser == ST_FATAL);

	`RCS_ASSERT_NEXT(a_stall_hold, m_axis_tvalid && !m_axis_tready,
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
	`RCS_ASSERT_SAME(a_fatal_zero, fatal, m_axis_tdata == '0)
	`RCS_ASSERT_SAME(a_rel_flag, built, m_axis_tdata[31] == m_axis_tdata[65])
	`RCS_ASSERT_SAME(a_min_size, built, m_axis_tdata[90:79] >= LEN_W'(HDR_BYTES))

endmodule

bind reliable_channel_sequencer_core rcs_checker u_rcs_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire
